FILE: hw/rtl/sc1kt_pkg.sv
// Package with the shared types, scancode constants and lookup tables of the set-1 translator.
`timescale 1ns / 1ps

package sc1kt_pkg;

    localparam int ScWidth   = 8;
    localparam int CodeWidth = 8;

    localparam logic [7:0] SC_PREFIX     = 8'hE0;
    localparam logic [6:0] SC_LSHIFT     = 7'h2A;
    localparam logic [6:0] SC_RSHIFT     = 7'h36;
    localparam logic [6:0] SC_CTRL       = 7'h1D;
    localparam logic [6:0] SC_ALT        = 7'h38;
    localparam logic [6:0] SC_CAPS       = 7'h3A;
    localparam logic [6:0] SC_NUMLOCK    = 7'h45;
    localparam logic [6:0] SC_BACKSPACE  = 7'h0E;
    localparam logic [6:0] SC_ENTER      = 7'h1C;
    localparam logic [6:0] SC_TAB        = 7'h0F;
    localparam logic [6:0] SC_PAD_STAR   = 7'h37;
    localparam logic [6:0] SC_PAD_FIRST  = 7'h47;
    localparam logic [6:0] SC_PAD_LAST   = 7'h53;
    localparam logic [6:0] SC_PAD_MINUS  = 7'h4A;
    localparam logic [6:0] SC_PAD_PLUS   = 7'h4E;
    localparam logic [6:0] SC_F1         = 7'h3B;
    localparam logic [6:0] SC_F10        = 7'h44;
    localparam logic [6:0] SC_F11        = 7'h57;
    localparam logic [6:0] SC_F12        = 7'h58;
    localparam logic [6:0] SC_ROM_LIMIT  = 7'h40;
    localparam logic [6:0] SC_UP         = 7'h48;
    localparam logic [6:0] SC_DOWN       = 7'h50;
    localparam logic [6:0] SC_LEFT       = 7'h4B;
    localparam logic [6:0] SC_RIGHT      = 7'h4D;
    localparam logic [6:0] SC_HOME       = 7'h47;
    localparam logic [6:0] SC_END        = 7'h4F;
    localparam logic [6:0] SC_PGUP       = 7'h49;
    localparam logic [6:0] SC_PGDN       = 7'h51;
    localparam logic [6:0] SC_INSERT     = 7'h52;
    localparam logic [6:0] SC_DELETE     = 7'h53;
    localparam logic [6:0] SC_SLASH      = 7'h35;

    localparam logic [7:0] KEY_CTRL      = 8'h01;
    localparam logic [7:0] KEY_BACKSPACE = 8'h08;
    localparam logic [7:0] KEY_TAB       = 8'h09;
    localparam logic [7:0] KEY_ENTER     = 8'h0D;
    localparam logic [7:0] KEY_STAR      = 8'h2A;
    localparam logic [7:0] KEY_MINUS     = 8'h2D;
    localparam logic [7:0] KEY_PLUS      = 8'h2B;
    localparam logic [7:0] KEY_SLASH     = 8'h2F;
    localparam logic [7:0] KEY_UP        = 8'hAD;
    localparam logic [7:0] KEY_DOWN      = 8'hAF;
    localparam logic [7:0] KEY_LEFT      = 8'hAC;
    localparam logic [7:0] KEY_RIGHT     = 8'hAE;
    localparam logic [7:0] KEY_NONE      = 8'h00;
    localparam logic [7:0] CHAR_LOW_A    = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z    = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    typedef struct packed {
        logic shift;
        logic caps;
        logic num;
        logic prefix;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{shift: 1'b0, caps: 1'b0, num: 1'b1, prefix: 1'b0};

    typedef struct packed {
        logic                 emit;
        logic                 pressed;
        logic [CodeWidth-1:0] code;
        flags_t               flags;
    } xlate_t;

    localparam logic [7:0] BASE_ROM [64] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] SHIFT_ROM [64] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h7B, 8'h7D, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] PAD_DIGIT [16] = '{
        8'h37, 8'h38, 8'h39, 8'h00, 8'h34, 8'h35, 8'h36, 8'h00,
        8'h31, 8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] PAD_NAV [16] = '{
        8'hC7, 8'hAD, 8'hC9, 8'h00, 8'hAC, 8'h00, 8'hAE, 8'h00,
        8'hCF, 8'hAF, 8'hD1, 8'hD2, 8'hD3, 8'h00, 8'h00, 8'h00
    };

    // Translates one scancode against the current flags into an optional event and new flags.
    function automatic xlate_t translate(input logic [ScWidth-1:0] raw, input flags_t fl);
        xlate_t     r;
        logic [6:0] sc;
        logic [6:0] pad_off;
        logic [7:0] ch;
        logic [7:0] sym;
        r.emit    = 1'b0;
        r.pressed = ~raw[7];
        r.code    = KEY_NONE;
        r.flags   = fl;
        sc        = raw[6:0];
        pad_off   = sc - SC_PAD_FIRST;
        ch        = BASE_ROM[sc[5:0]];
        sym       = fl.num ? PAD_DIGIT[pad_off[3:0]] : PAD_NAV[pad_off[3:0]];
        if (raw == SC_PREFIX) begin
            r.flags.prefix = 1'b1;
        end else if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
            r.flags.shift = ~raw[7];
        end else if (sc == SC_CTRL && !fl.prefix) begin
            r.emit = 1'b1;
            r.code = KEY_CTRL;
        end else if (sc == SC_ALT && !fl.prefix) begin
            r.emit = 1'b0;
        end else if (sc == SC_CAPS && !raw[7]) begin
            r.flags.caps = ~fl.caps;
        end else if (sc == SC_NUMLOCK && !raw[7]) begin
            r.flags.num    = ~fl.num;
            r.flags.prefix = 1'b0;
        end else if (sc == SC_BACKSPACE) begin
            r.flags.prefix = 1'b0;
            r.emit         = 1'b1;
            r.code         = KEY_BACKSPACE;
        end else if (sc == SC_ENTER) begin
            r.flags.prefix = 1'b0;
            r.emit         = 1'b1;
            r.code         = KEY_ENTER;
        end else if (sc == SC_TAB) begin
            r.flags.prefix = 1'b0;
            r.emit         = 1'b1;
            r.code         = KEY_TAB;
        end else if (sc == SC_PAD_STAR && !fl.prefix) begin
            r.emit = 1'b1;
            r.code = KEY_STAR;
        end else if (fl.prefix) begin
            r.flags.prefix = 1'b0;
            r.emit         = 1'b1;
            case (sc) inside
                SC_UP:    r.code = KEY_UP;
                SC_DOWN:  r.code = KEY_DOWN;
                SC_LEFT:  r.code = KEY_LEFT;
                SC_RIGHT: r.code = KEY_RIGHT;
                SC_HOME, SC_END, SC_PGUP, SC_PGDN, SC_INSERT, SC_DELETE:
                    r.code = {1'b1, sc};
                SC_SLASH: r.code = KEY_SLASH;
                SC_CTRL:  r.code = KEY_CTRL;
                default:  r.emit = 1'b0;
            endcase
        end else if (sc inside {[SC_PAD_FIRST:SC_PAD_LAST]}) begin
            if (sc == SC_PAD_MINUS) begin
                r.emit = 1'b1;
                r.code = KEY_MINUS;
            end else if (sc == SC_PAD_PLUS) begin
                r.emit = 1'b1;
                r.code = KEY_PLUS;
            end else begin
                r.emit = (sym != KEY_NONE);
                r.code = sym;
            end
        end else if (sc inside {[SC_F1:SC_F10], SC_F11, SC_F12}) begin
            r.emit = 1'b1;
            r.code = {1'b1, sc};
        end else if (sc < SC_ROM_LIMIT && ch != KEY_NONE) begin
            r.emit = 1'b1;
            if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
                r.code = (fl.shift != fl.caps) ? ch - CASE_OFFSET : ch;
            end else if (fl.shift && SHIFT_ROM[sc[5:0]] != KEY_NONE) begin
                r.code = SHIFT_ROM[sc[5:0]];
            end else begin
                r.code = ch;
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/scancode_set1_key_translator.sv
// Top level of the set-1 scancode to key event translator.
`timescale 1ns / 1ps
//
// The block takes one raw set-1 scancode byte per word on the s_axis channel and
// gives at most one key event per byte on the m_axis channel. The event code is in
// m_axis_tdata and the press flag in m_axis_tuser (1 for press, 0 for release).
// Prefix bytes, shift and alt keys, lock keys and unmapped keys give no event;
// prefix, shift and lock keys update the internal flags. Ctrl gives an event.
// A byte is registered in an input register and translated by a single
// pass through the lookup logic into the output register, which drives its
// event onto m_axis. One byte is taken every cycle as
// long as the output register is free or is being read in the same cycle.
// Reset clears the valid flags of both registers, clears shift, caps lock and the prefix, and sets num
// lock. When the receiver stalls, the output word holds and the byte waiting in the
// input register stays there; s_axis_tready then drops once that register is full.
module scancode_set1_key_translator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sc1kt_pkg::ScWidth-1:0]   s_axis_tdata,   // scancode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sc1kt_pkg::CodeWidth-1:0] m_axis_tdata,   // key_code
    output logic                            m_axis_tuser    // key_pressed
);
    import sc1kt_pkg::*;

    logic                 in_valid_reg;
    logic [ScWidth-1:0]   in_data_reg;
    flags_t               flags_reg;
    logic                 out_valid_reg;
    logic                 out_pressed_reg;
    logic [CodeWidth-1:0] out_code_reg;
    logic                 out_free;
    logic                 advance;
    xlate_t               xl;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign xl            = translate(in_data_reg, flags_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= FLAGS_RESET;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                flags_reg     <= xl.flags;
                out_valid_reg <= xl.emit;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_data_reg <= s_axis_tdata;
        end
        if (advance && xl.emit) begin
            out_pressed_reg <= xl.pressed;
            out_code_reg    <= xl.code;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_code_reg;
    assign m_axis_tuser  = out_pressed_reg;

endmodule

FILE: hw/rtl/sc1kt_checker.sv
// Port checker for the set-1 scancode translator and its bind to the top level.
`timescale 1ns / 1ps

module sc1kt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [sc1kt_pkg::ScWidth-1:0]   s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sc1kt_pkg::CodeWidth-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);
    import sc1kt_pkg::*;

    logic s_word;

    assign s_word = s_axis_tvalid && s_axis_tready;

    // A reset leaves no event on the output.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("m_axis_tvalid high after reset");

    // A word offered but not yet taken keeps its scancode.
    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("waiting input word changed");

    // A stalled event keeps its code and press flag.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled event changed");

    // A fresh event comes from an accepted input byte that passed through the input register.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_word, 2))
        else $error("event without a matching input word");

    // Every event carries a nonzero code.
    a_code_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata != KEY_NONE)
        else $error("event with a zero key code");

endmodule

bind scancode_set1_key_translator sc1kt_checker u_sc1kt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/key_event_sb_pkg.sv
// Package with the key event scoreboard and its translation tables for the set-1 translator bench.
`timescale 1ns / 1ps

package key_event_sb_pkg;

    import sc1kt_pkg::*;

    localparam logic [7:0] KEY_EXT_BASE = 8'h80;

    typedef struct packed {
        logic       pressed;
        logic [7:0] code;
    } key_event_t;

    localparam logic [7:0] LOWER_MAP [64] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] UPPER_MAP [64] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h7B, 8'h7D, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] PAD_NUM_MAP [13] = '{
        8'h37, 8'h38, 8'h39, 8'h00, 8'h34, 8'h35, 8'h36, 8'h00,
        8'h31, 8'h32, 8'h33, 8'h30, 8'h2E
    };

    localparam logic [7:0] PAD_NAV_MAP [13] = '{
        8'hC7, 8'hAD, 8'hC9, 8'h00, 8'hAC, 8'h00, 8'hAE, 8'h00,
        8'hCF, 8'hAF, 8'hD1, 8'hD2, 8'hD3
    };

    class key_event_scoreboard;

        logic       shift_down;
        logic       caps_on;
        logic       num_on;
        logic       e0_pending;
        key_event_t expected_events [$];
        int         errors;
        int         bytes_noted;
        int         events_checked;
        int         lock_toggles;
        int         prefixed_events;

        function new();
            shift_down      = 1'b0;
            caps_on         = 1'b0;
            num_on          = 1'b1;
            e0_pending      = 1'b0;
            errors          = 0;
            bytes_noted     = 0;
            events_checked  = 0;
            lock_toggles    = 0;
            prefixed_events = 0;
        endfunction

        function void note_scancode(logic [7:0] raw);
            logic       press;
            logic [6:0] key;
            logic [6:0] pad_off;
            logic       emit;
            logic [7:0] code;
            key_event_t ev;
            press = ~raw[7];
            key   = raw[6:0];
            emit  = 1'b0;
            code  = KEY_NONE;
            bytes_noted++;
            if (raw == SC_PREFIX) begin
                e0_pending = 1'b1;
            end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
                shift_down = press;
            end else if (key == SC_CTRL && !e0_pending) begin
                emit = 1'b1;
                code = KEY_CTRL;
            end else if (key == SC_ALT && !e0_pending) begin
                emit = 1'b0;
            end else if (key == SC_CAPS && press) begin
                caps_on = ~caps_on;
                lock_toggles++;
            end else if (key == SC_NUMLOCK && press) begin
                num_on     = ~num_on;
                e0_pending = 1'b0;
                lock_toggles++;
            end else if (key == SC_BACKSPACE) begin
                e0_pending = 1'b0;
                emit       = 1'b1;
                code       = KEY_BACKSPACE;
            end else if (key == SC_ENTER) begin
                e0_pending = 1'b0;
                emit       = 1'b1;
                code       = KEY_ENTER;
            end else if (key == SC_TAB) begin
                e0_pending = 1'b0;
                emit       = 1'b1;
                code       = KEY_TAB;
            end else if (key == SC_PAD_STAR && !e0_pending) begin
                emit = 1'b1;
                code = KEY_STAR;
            end else if (e0_pending) begin
                e0_pending = 1'b0;
                case (key)
                    SC_UP:    code = KEY_UP;
                    SC_DOWN:  code = KEY_DOWN;
                    SC_LEFT:  code = KEY_LEFT;
                    SC_RIGHT: code = KEY_RIGHT;
                    SC_HOME, SC_END, SC_PGUP, SC_PGDN, SC_INSERT, SC_DELETE:
                        code = KEY_EXT_BASE + key;
                    SC_SLASH: code = KEY_SLASH;
                    SC_CTRL:  code = KEY_CTRL;
                    default:  code = KEY_NONE;
                endcase
                emit = (code != KEY_NONE);
                if (emit) prefixed_events++;
            end else if (key >= SC_PAD_FIRST && key <= SC_PAD_LAST) begin
                pad_off = key - SC_PAD_FIRST;
                if (key == SC_PAD_MINUS) begin
                    code = KEY_MINUS;
                end else if (key == SC_PAD_PLUS) begin
                    code = KEY_PLUS;
                end else begin
                    code = num_on ? PAD_NUM_MAP[pad_off[3:0]]
                                  : PAD_NAV_MAP[pad_off[3:0]];
                end
                emit = (code != KEY_NONE);
            end else if ((key >= SC_F1 && key <= SC_F10) || key == SC_F11 || key == SC_F12) begin
                emit = 1'b1;
                code = KEY_EXT_BASE + key;
            end else if (key < SC_ROM_LIMIT) begin
                code = LOWER_MAP[key[5:0]];
                emit = (code != KEY_NONE);
                if (code >= CHAR_LOW_A && code <= CHAR_LOW_Z) begin
                    if (shift_down != caps_on) code = code - CASE_OFFSET;
                end else if (shift_down && UPPER_MAP[key[5:0]] != KEY_NONE) begin
                    code = UPPER_MAP[key[5:0]];
                end
            end
            if (emit) begin
                ev.pressed = press;
                ev.code    = code;
                expected_events.push_back(ev);
            end
        endfunction

        function void check_event(logic pressed, logic [7:0] code);
            key_event_t want;
            if (expected_events.size() == 0) begin
                $error("key event with none pending: key_pressed %0b key_code 0x%02h",
                       pressed, code);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            events_checked++;
            if (pressed !== want.pressed) begin
                $error("key_pressed: expected %0b, actual %0b", want.pressed, pressed);
                errors++;
            end
            if (code !== want.code) begin
                $error("key_code: expected 0x%02h, actual 0x%02h", want.code, code);
                errors++;
            end
        endfunction

    endclass

endpackage

FILE: verif/testbench.sv
// Testbench top that drives scancode words into the set-1 translator and checks its key events.
`timescale 1ns / 1ps

module testbench;

    import sc1kt_pkg::*;
    import key_event_sb_pkg::*;

    localparam int         ITEM_TARGET = 950;
    localparam logic [7:0] BREAK_FLAG  = 8'h80;

    localparam logic [6:0] PREFIXED_KEYS [12] = '{
        SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_HOME, SC_END,
        SC_PGUP, SC_PGDN, SC_INSERT, SC_DELETE, SC_SLASH, SC_CTRL
    };

    localparam logic [7:0] OPENING_BYTES [29] = '{
        8'h00, 8'hFF, 8'h1E,
        {1'b0, SC_LSHIFT}, 8'h1E, 8'h02, {1'b1, SC_LSHIFT},
        {1'b0, SC_CAPS}, {1'b1, SC_CAPS}, 8'h1E,
        {1'b0, SC_CTRL}, SC_PREFIX, SC_PREFIX, {1'b0, SC_UP},
        SC_PREFIX, {1'b1, SC_CTRL}, {1'b0, SC_ALT}, SC_PREFIX, {1'b1, SC_ALT},
        {1'b0, SC_NUMLOCK}, {1'b1, SC_NUMLOCK}, 8'h4C, {1'b0, SC_HOME},
        {1'b0, SC_BACKSPACE}, {1'b0, SC_ENTER}, {1'b1, SC_TAB}, {1'b0, SC_PAD_STAR},
        {1'b0, SC_F1}, {1'b1, SC_F12}
    };

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [ScWidth-1:0]   s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [CodeWidth-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    key_event_scoreboard sb = new();
    bit                  steady_phase = 1'b0;
    int                  bytes_sent   = 0;

    scancode_set1_key_translator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic int draw_wait();
        return steady_phase ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic send_byte(input logic [7:0] scancode);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= scancode;
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_scancode(scancode);
        bytes_sent++;
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_events.size() != 0);
    endtask

    initial begin : stimulus
        int         kind;
        int         n_keys;
        bit         mid_hold_done;
        logic [3:0] pick;
        logic [7:0] key;
        logic [7:0] modifier;
        mid_hold_done = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
        hold_until_drained();
        while (bytes_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 15) == 0) steady_phase = !steady_phase;
            if (!mid_hold_done && bytes_sent >= ITEM_TARGET / 2) begin
                hold_until_drained();
                mid_hold_done = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                key = 8'($urandom_range(1, 8'h58));
                send_byte(key);
                if ($urandom_range(0, 3) != 0) send_byte(key | BREAK_FLAG);
            end else if (kind < 58) begin
                modifier = $urandom_range(0, 1) ? {1'b0, SC_LSHIFT} : {1'b0, SC_RSHIFT};
                send_byte(modifier);
                n_keys = $urandom_range(1, 3);
                repeat (n_keys) begin
                    key = 8'($urandom_range(2, 8'h35));
                    send_byte(key);
                    send_byte(key | BREAK_FLAG);
                end
                send_byte(modifier | BREAK_FLAG);
            end else if (kind < 76) begin
                if ($urandom_range(0, 4) != 0) begin
                    pick = 4'($urandom_range(0, 11));
                    key  = {1'b0, PREFIXED_KEYS[pick]};
                end else begin
                    key = 8'($urandom_range(0, 127));
                end
                send_byte(SC_PREFIX);
                send_byte(key);
                if ($urandom_range(0, 3) != 0) begin
                    send_byte(SC_PREFIX);
                    send_byte(key | BREAK_FLAG);
                end
            end else if (kind < 84) begin
                key = $urandom_range(0, 1) ? {1'b0, SC_CAPS} : {1'b0, SC_NUMLOCK};
                if ($urandom_range(0, 3) == 0) send_byte(SC_PREFIX);
                send_byte(key);
                send_byte(key | BREAK_FLAG);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
        s_axis_tvalid <= 1'b0;
        while (sb.expected_events.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("Run covered %0d scancode words and %0d checked key events.",
                 sb.bytes_noted, sb.events_checked);
        $display("It included %0d lock toggles and %0d prefixed key events.",
                 sb.lock_toggles, sb.prefixed_events);
        if (sb.errors == 0) begin
            $display("scancode_set1_key_translator test passed");
        end else begin
            $display("scancode_set1_key_translator test failed");
        end
        $finish;
    end

    initial begin : event_sink
        int stall;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            sb.check_event(m_axis_tuser, m_axis_tdata);
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("scancode_set1_key_translator test failed");
        $finish;
    end

endmodule
